FILE: rtl/tsr_pkg.sv
package tsr_pkg;

    // Default and largest depth of the out-of-order byte store.
    localparam int unsigned STORE_DEPTH_DEF = 64;
    localparam int unsigned STORE_DEPTH_MAX = 64;

    // Window capacity after reset.
    localparam logic [6:0] WINDOW_CAP_RESET = 7'd64;

    // One input request: a byte (or empty segment) at an absolute stream position.
    typedef struct packed {
        logic [31:0] stream_index;
        logic [7:0]  in_byte;
        logic        byte_valid;
        logic        eof_flag;
        logic [31:0] consumer_read_count;
    } tsr_in_t;

    // One result request: an assembled byte or a status word.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        out_last;
        logic        stream_ended;
        logic [6:0]  unassembled_count;
        logic        store_empty;
        logic [31:0] next_index;
    } tsr_out_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_STORE,
        ST_SCAN,
        ST_FINISH,
        ST_READ,
        ST_SEND,
        ST_STATUS
    } tsr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic eval;
        logic store;
        logic scan_step;
        logic finish;
        logic rd_issue;
        logic load_byte;
        logic load_status;
    } tsr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ended;
        logic scan_hit;
        logic run_zero;
        logic out_free;
    } tsr_sts_t;

endpackage

FILE: rtl/tsr_ctrl.sv
module tsr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tsr_pkg::tsr_sts_t sts,
    output tsr_pkg::tsr_cmd_t cmd
);
    import tsr_pkg::*;

    tsr_state_t state_reg;
    tsr_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands for each step of one request.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (sts.ended) begin
                    state_next = ST_STATUS;
                end else begin
                    cmd.eval   = 1'b1;
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.scan_hit) begin
                    cmd.scan_step = 1'b1;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = sts.run_zero ? ST_STATUS : ST_READ;
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND: begin
                if (sts.out_free) begin
                    cmd.load_byte = 1'b1;
                    state_next    = sts.run_zero ? ST_IDLE : ST_READ;
                end
            end
            ST_STATUS: begin
                if (sts.out_free) begin
                    cmd.load_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/tsr_datapath.sv
module tsr_datapath #(
    parameter int unsigned STORE_DEPTH = tsr_pkg::STORE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tsr_pkg::tsr_in_t  s_data,
    input  logic              cfg_valid,
    input  logic [6:0]        cfg_data,
    input  tsr_pkg::tsr_cmd_t cmd,
    output tsr_pkg::tsr_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output tsr_pkg::tsr_out_t m_data
);
    import tsr_pkg::*;

    localparam int unsigned PTR_W = $clog2(STORE_DEPTH);
    localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [PTR_W:0]   DEPTH_PTR = (PTR_W + 1)'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);
    localparam logic [6:0]       DEPTH_CAP = 7'(STORE_DEPTH);
    localparam logic [31:0]      DEPTH_IDX = 32'(STORE_DEPTH);

    // Slot pointer addition modulo the store depth; both operands are below it.
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_PTR) begin
            sum = sum - DEPTH_PTR;
        end
        return sum[PTR_W-1:0];
    endfunction

    tsr_in_t          in_reg;
    logic [6:0]       cap_reg;
    logic [31:0]      assembled_reg;
    logic [31:0]      eof_pos_reg;
    logic             eof_known_reg;
    logic [6:0]       pending_reg;
    logic             ended_reg;
    logic [STORE_DEPTH-1:0] slot_valid_reg;
    logic [PTR_W-1:0] head_reg;
    logic             store_ok_reg;
    logic [PTR_W-1:0] off_reg;
    logic [CNT_W-1:0] run_reg;
    logic [PTR_W-1:0] scan_ptr_reg;
    logic [7:0]       rd_data_reg;
    tsr_out_t         out_reg;
    logic             m_valid_reg;
    logic [7:0]       mem [STORE_DEPTH];

    logic [6:0]       cap_eff;
    logic [32:0]      limit;
    logic [31:0]      ahead;
    logic             in_window;
    logic [PTR_W-1:0] slot;
    logic             store_hit;
    logic [31:0]      assembled_next;
    logic             ended_next;
    tsr_out_t         status_word;
    tsr_out_t         byte_word;
    tsr_out_t         last_word;

    // Acceptance window for the captured byte.
    always_comb begin
        cap_eff   = (cap_reg > DEPTH_CAP) ? DEPTH_CAP : cap_reg;
        limit     = {1'b0, in_reg.consumer_read_count} + 33'(cap_eff);
        ahead     = in_reg.stream_index - assembled_reg;
        in_window = in_reg.byte_valid && (in_reg.stream_index >= assembled_reg)
                    && ({1'b0, in_reg.stream_index} < limit) && (ahead < DEPTH_IDX);
    end

    // Slot of the captured byte, relative to the slot of the next expected index.
    assign slot      = wrap_add(head_reg, off_reg);
    assign store_hit = store_ok_reg && !slot_valid_reg[slot];

    // Assembled index and end detection once the contiguous run is known.
    assign assembled_next = assembled_reg + 32'(run_reg);
    assign ended_next     = eof_known_reg && (assembled_next == eof_pos_reg);

    // Status fields carried by every result of the request.
    always_comb begin
        status_word                   = '0;
        status_word.stream_ended      = ended_reg;
        status_word.unassembled_count = pending_reg;
        status_word.store_empty       = (pending_reg == 7'd0);
        status_word.next_index        = assembled_reg;
    end

    // Output words for an assembled byte and for a status-only result.
    always_comb begin
        byte_word           = status_word;
        byte_word.out_byte  = rd_data_reg;
        byte_word.out_valid = 1'b1;
        byte_word.out_last  = sts.run_zero;
        last_word           = status_word;
        last_word.out_last  = 1'b1;
    end

    // Status towards the controller.
    always_comb begin
        sts.ended    = ended_reg;
        sts.scan_hit = slot_valid_reg[scan_ptr_reg] && (run_reg != DEPTH_CNT);
        sts.run_zero = (run_reg == '0);
        sts.out_free = !m_valid_reg || m_ready;
    end

    // Control state of the reassembler.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg        <= WINDOW_CAP_RESET;
            assembled_reg  <= '0;
            eof_pos_reg    <= '0;
            eof_known_reg  <= 1'b0;
            pending_reg    <= '0;
            ended_reg      <= 1'b0;
            slot_valid_reg <= '0;
            head_reg       <= '0;
            store_ok_reg   <= 1'b0;
            run_reg        <= '0;
            scan_ptr_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (cmd.eval) begin
                store_ok_reg <= in_window;
                if (in_reg.eof_flag) begin
                    eof_pos_reg   <= in_reg.stream_index + 32'(in_reg.byte_valid);
                    eof_known_reg <= 1'b1;
                end
            end
            if (cmd.store) begin
                if (store_hit) begin
                    slot_valid_reg[slot] <= 1'b1;
                    pending_reg          <= pending_reg + 7'd1;
                end
                run_reg      <= '0;
                scan_ptr_reg <= head_reg;
            end
            if (cmd.scan_step) begin
                run_reg      <= run_reg + CNT_W'(1);
                scan_ptr_reg <= wrap_add(scan_ptr_reg, PTR_W'(1));
            end
            if (cmd.finish) begin
                assembled_reg <= assembled_next;
                pending_reg   <= pending_reg - 7'(run_reg);
                if (ended_next) begin
                    ended_reg     <= 1'b1;
                    eof_known_reg <= 1'b0;
                end
            end
            if (cmd.rd_issue) begin
                slot_valid_reg[head_reg] <= 1'b0;
                head_reg <= wrap_add(head_reg, PTR_W'(1));
                run_reg  <= run_reg - CNT_W'(1);
            end
            if (cmd.load_byte || cmd.load_status) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: captured request, offset and the output word.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.eval) begin
            off_reg <= ahead[PTR_W-1:0];
        end
        if (cmd.load_byte) begin
            out_reg <= byte_word;
        end else if (cmd.load_status) begin
            out_reg <= last_word;
        end
    end

    // Byte store: written on a fresh store, read at the head while draining.
    always_ff @(posedge aclk) begin
        if (cmd.store && store_hit) begin
            mem[slot] <= in_reg.in_byte;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    // A drain read only ever takes a slot that holds a byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> slot_valid_reg[head_reg])
        else $error("drain read of an empty slot");

    // Once the stream has ended it stays ended.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ended_reg |=> ended_reg)
        else $error("end of stream cleared");

    // The count of stored bytes never exceeds the store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= DEPTH_CAP)
        else $error("pending count beyond store depth");

    // A result is loaded only when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_byte || cmd.load_status) |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

FILE: rtl/tcp_stream_reassembler_core.sv
// Channel    | Ports                           | Carries
// -----------+---------------------------------+-------------------------------------
// input      | s_valid, s_ready, s_data        | one byte or empty segment request
// result     | m_valid, m_ready, m_data        | one assembled byte or a status word
// config     | cfg_valid, cfg_ready, cfg_data  | window capacity (always ready)
//
// A request steps through capture, window check, store, a scan of the stored run
// and a finish step, then a registered store read and an output load per byte it
// makes contiguous. With no such byte, its status result follows the finish step,
// or the capture once the stream has ended. Reset is synchronous, active low, and
// clears all slot valid bits at once. A stalled result holds the controller in its
// send or status step; a new request is taken while the last result still waits.
module tcp_stream_reassembler_core #(
    parameter int unsigned STORE_DEPTH = tsr_pkg::STORE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tsr_pkg::tsr_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output tsr_pkg::tsr_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [6:0]       cfg_data
);
    import tsr_pkg::*;

    tsr_cmd_t cmd;
    tsr_sts_t sts;

    // The capacity register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencer for one request.
    tsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Window check, byte store, run scan and output register.
    tsr_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
